[hdl/sha1_pkg.sv]
// sha1_pkg: shared types and constants for the sha-1 hash engine
// no dependencies
package sha1_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        start_msg;
    logic        end_msg;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } sha1_out_t;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_USE_MID = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MID_H0  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MID_H1  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MID_H2  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MID_H3  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MID_H4  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MID_LEN = 3'd6;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) k = 32'h5A827999;
    else if (t < 7'd40) k = 32'h6ED9EBA1;
    else if (t < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

endpackage

[hdl/sha1_round.sv]
// sha1_round: one sha-1 round per cycle while step is high, over the working variables and the
// 16-entry schedule window; depends on sha1_pkg
module sha1_round import sha1_pkg::*; (
  input  logic          clk,
  input  logic          ld,
  input  logic [159:0]  ld_abcde,
  input  logic          step,
  input  logic [6:0]    t,
  input  logic [511:0]  blk,
  output logic [159:0]  abcde
);

  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic [31:0] w, f, tmp, wn;
  logic [3:0]  ti;

  assign ti = t[3:0];
  assign wn = {w_r[(ti + 4'd13)] ^ w_r[(ti + 4'd8)] ^ w_r[(ti + 4'd2)] ^ w_r[ti]};

  always_comb begin
    if (t < 7'd16) w = w_r[ti];
    else w = {wn[30:0], wn[31]};
    if (t < 7'd20) f = (b_r & c_r) | (~b_r & d_r);
    else if (t < 7'd40 || t >= 7'd60) f = b_r ^ c_r ^ d_r;
    else f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    tmp = {a_r[26:0], a_r[31:27]} + f + e_r + w + round_k(t);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      {a_r, b_r, c_r, d_r, e_r} <= ld_abcde;
      for (int i = 0; i < 16; i++) w_r[i] <= blk[511 - 32*i -: 32];
    end else if (step) begin
      w_r[ti] <= w;
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= tmp;
    end
  end

  assign abcde = {a_r, b_r, c_r, d_r, e_r};

endmodule

[hdl/sha1_hash_engine.sv]
// sha1_hash_engine: top level, word buffering, padding and sequencing
// depends on sha1_pkg and sha1_round
//
// usage: message words enter on in_valid/in_ready as sha1_in_t. start_msg
// loads the chaining value and byte count from the standard values or the
// midstate registers (cfg_*, indexes 0..6). each accepted word is stored in
// the block buffer; the sixteenth word of a block starts the compression: a
// load state, 80 rounds at one round per cycle in the shared round unit and
// a chaining add state, and in_ready is low meanwhile. an end word is
// padded: the pad and length words are fed one per cycle, pausing for each
// compression, into the same buffer, which runs one or two more compressions.
// then five digest words leave on out_valid/out_ready, one per accepted
// transfer; a stall on the output holds the digest word and the engine waits.
// reset (rst_n low, synchronous) restores the standard chaining value,
// clears counters and config registers to their reset values.
module sha1_hash_engine import sha1_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha1_in_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sha1_out_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [60:0]         cfg_wdata
);

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic         use_mid_r;
  logic [159:0] mid_r;
  logic [60:0]  mid_len_r;
  logic [159:0] h_r;
  logic [60:0]  bytes_r;
  logic [3:0]   pos_r;
  logic [6:0]   t_r;
  logic [511:0] blk_r;
  logic         fin_r;
  logic [2:0]   pend_r;
  logic [1:0]   seq_r;
  logic [2:0]   oi_r;
  logic         ld, step;
  logic [159:0] abcde;
  logic [31:0]  mask, mark, pw;
  logic [2:0]   vb;
  logic [63:0]  bits;

  sha1_round u_round (
    .clk(clk), .ld(ld), .ld_abcde(h_r), .step(step), .t(t_r),
    .blk(blk_r), .abcde(abcde)
  );

  assign in_ready  = (state_r == S_IN);
  assign out_valid = (state_r == S_OUT);
  assign out_data.digest_word = h_r[159 - 32*oi_r -: 32];
  assign out_data.word_index  = oi_r;
  assign out_data.digest_last = (oi_r == 3'd4);
  assign step = (state_r == S_RUN);
  assign bits = {bytes_r, 3'b000};

  always_comb begin
    vb = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
    unique case (vb)
      3'd0: begin mask = 32'h0; mark = {PAD_BYTE, 24'h0}; end
      3'd1: begin mask = 32'hFF000000; mark = {8'h0, PAD_BYTE, 16'h0}; end
      3'd2: begin mask = 32'hFFFF0000; mark = {16'h0, PAD_BYTE, 8'h0}; end
      3'd3: begin mask = 32'hFFFFFF00; mark = {24'h0, PAD_BYTE}; end
      default: begin mask = 32'hFFFFFFFF; mark = 32'h0; end
    endcase
    // pad sequence words: pend 1 = 0x80 word, 2 = zero fill, 3 = len hi, 4 = len lo
    unique case (pend_r)
      3'd1: pw = {PAD_BYTE, 24'h0};
      3'd3: pw = bits[63:32];
      3'd4: pw = bits[31:0];
      default: pw = 32'h0;
    endcase
  end

  assign ld = (state_r == S_PAD && seq_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IN;
      use_mid_r <= 1'b0;
      mid_r     <= {IV0, IV1, IV2, IV3, IV4};
      mid_len_r <= '0;
      h_r       <= {IV0, IV1, IV2, IV3, IV4};
      bytes_r   <= '0;
      pos_r     <= '0;
      t_r       <= '0;
      fin_r     <= 1'b0;
      pend_r    <= '0;
      seq_r     <= '0;
      oi_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_USE_MID: use_mid_r <= cfg_wdata[0];
          CFG_MID_H0:  mid_r[159:128] <= cfg_wdata[31:0];
          CFG_MID_H1:  mid_r[127:96]  <= cfg_wdata[31:0];
          CFG_MID_H2:  mid_r[95:64]   <= cfg_wdata[31:0];
          CFG_MID_H3:  mid_r[63:32]   <= cfg_wdata[31:0];
          CFG_MID_H4:  mid_r[31:0]    <= cfg_wdata[31:0];
          CFG_MID_LEN: mid_len_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IN: begin
          if (in_valid) begin
            logic [3:0]   p;
            logic [159:0] h;
            logic [60:0]  nb;
            p  = in_data.start_msg ? 4'd0 : pos_r;
            h  = in_data.start_msg ? (use_mid_r ? mid_r : {IV0, IV1, IV2, IV3, IV4}) : h_r;
            nb = in_data.start_msg ? (use_mid_r ? mid_len_r : 61'd0) : bytes_r;
            h_r <= h;
            if (!in_data.end_msg) begin
              bytes_r <= nb + 61'd4;
              blk_r[511 - 32*p -: 32] <= in_data.data_word;
              pos_r <= p + 4'd1;
              if (p == 4'd15) begin
                seq_r <= 2'd1;
                fin_r <= 1'b0;
                pend_r <= 3'd0;
                state_r <= S_PAD;
              end
            end else begin
              bytes_r <= nb + {58'd0, vb};
              blk_r[511 - 32*p -: 32] <= (in_data.data_word & mask) | mark;
              pos_r <= p + 4'd1;
              fin_r <= 1'b1;
              pend_r <= (vb == 3'd4) ? 3'd1 : ((p == 4'd13) ? 3'd3 : 3'd2);
              seq_r <= (p == 4'd15) ? 2'd1 : 2'd0;
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (seq_r == 2'd1) begin
            t_r <= '0;
            seq_r <= 2'd0;
            state_r <= S_RUN;
          end else begin
            logic [2:0] np;
            blk_r[511 - 32*pos_r -: 32] <= pw;
            pos_r <= pos_r + 4'd1;
            np = pend_r;
            if (pend_r == 3'd1 || pend_r == 3'd2)
              np = (pos_r + 4'd1 == 4'd14) ? 3'd3 : 3'd2;
            else if (pend_r == 3'd3) np = 3'd4;
            else np = 3'd5;
            // after the 0x80 word at pos 14 or 15, zero fill and spill into a new block
            if (pend_r == 3'd1 && pos_r == 4'd14) np = 3'd2;
            if (pend_r == 3'd1 && pos_r == 4'd15) np = 3'd2;
            pend_r <= np;
            if (pos_r == 4'd15) seq_r <= 2'd1;
          end
        end
        S_RUN: begin
          t_r <= t_r + 7'd1;
          if (t_r == 7'd79) state_r <= S_ADD;
        end
        S_ADD: begin
          h_r <= {h_r[159:128] + abcde[159:128], h_r[127:96] + abcde[127:96],
                  h_r[95:64] + abcde[95:64], h_r[63:32] + abcde[63:32],
                  h_r[31:0] + abcde[31:0]};
          if (!fin_r) state_r <= S_IN;
          else if (pend_r == 3'd5) begin
            oi_r <= '0;
            state_r <= S_OUT;
          end else state_r <= S_PAD;
        end
        S_OUT: begin
          if (out_ready) begin
            oi_r <= oi_r + 3'd1;
            if (oi_r == 3'd4) begin
              bytes_r <= '0;
              pos_r <= '0;
              fin_r <= 1'b0;
              state_r <= S_IN;
            end
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

endmodule

[dv/tb_top.sv]
// tb_top: self-checking testbench for sha1_hash_engine
// depends on sha1_pkg and the engine rtl; predicts digests and compares them word by word
`timescale 1ns / 100ps

module tb_top;
  import sha1_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  sha1_in_t in_data;
  sha1_out_t out_data;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [60:0] cfg_wdata;

  sha1_hash_engine DUT (.*);

  class digest_scoreboard;
    bit use_mid;
    logic [31:0] mid_h[5];
    logic [60:0] mid_len;
    logic [31:0] chain[5];
    logic [31:0] sched[16];
    logic [60:0] nbytes;
    int unsigned wpos;
    sha1_out_t pending[$];
    int errors;
    int digests;

    function void init();
      logic [31:0] iv[5];
      iv = '{IV0, IV1, IV2, IV3, IV4};
      use_mid = 0;
      mid_len = '0;
      for (int i = 0; i < 5; i++) begin
        mid_h[i] = iv[i];
        chain[i] = iv[i];
      end
      nbytes = '0;
      wpos = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [60:0] v);
      case (idx)
        CFG_USE_MID: use_mid = v[0];
        CFG_MID_H0: mid_h[0] = v[31:0];
        CFG_MID_H1: mid_h[1] = v[31:0];
        CFG_MID_H2: mid_h[2] = v[31:0];
        CFG_MID_H3: mid_h[3] = v[31:0];
        CFG_MID_H4: mid_h[4] = v[31:0];
        CFG_MID_LEN: mid_len = v;
        default: ;
      endcase
    endfunction

    function void compress_block();
      logic [31:0] a, b, c, d, e, f, k, t;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r >= 16) begin
          t = sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^ sched[(r + 2) % 16] ^ sched[r % 16];
          sched[r % 16] = {t[30:0], t[31]};
        end
        if (r < 20) begin
          f = (b & c) | (~b & d); k = 32'h5A827999;
        end else if (r < 40) begin
          f = b ^ c ^ d; k = 32'h6ED9EBA1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d; k = 32'hCA62C1D6;
        end
        t = {a[26:0], a[31:27]} + f + e + sched[r % 16] + k;
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void push(logic [31:0] w);
      sched[wpos] = w;
      wpos = (wpos + 1) % 16;
      if (wpos == 0) compress_block();
    endfunction

    function void note_word(sha1_in_t it);
      logic [31:0] iv[5];
      logic [63:0] bits;
      int unsigned vb;
      iv = '{IV0, IV1, IV2, IV3, IV4};
      if (it.start_msg) begin
        for (int i = 0; i < 5; i++) chain[i] = use_mid ? mid_h[i] : iv[i];
        nbytes = use_mid ? mid_len : '0;
        wpos = 0;
      end
      if (!it.end_msg) begin
        nbytes += 61'd4;
        push(it.data_word);
        return;
      end
      vb = (it.valid_bytes > 4) ? 4 : it.valid_bytes;
      nbytes += 61'(vb);
      if (vb == 4) begin
        push(it.data_word);
        push(32'h8000_0000);
      end else begin
        push((it.data_word & ~(32'hFFFF_FFFF >> (8 * vb))) |
             (32'({PAD_BYTE}) << (24 - 8 * vb)));
      end
      if (wpos > 14) while (wpos != 0) push(0);
      while (wpos < 14) push(0);
      bits = {nbytes, 3'b000};
      push(bits[63:32]);
      push(bits[31:0]);
      for (int i = 0; i < 5; i++) pending.push_back('{chain[i], 3'(i), i == 4});
      nbytes = '0;
      wpos = 0;
    endfunction

    function void check_word(sha1_out_t got);
      sha1_out_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest word %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got.digest_last) digests++;
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("digest mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
                   exp.digest_word, exp.word_index, exp.digest_last,
                   got.digest_word, got.word_index, got.digest_last);
      end
    endfunction
  endclass

  digest_scoreboard sb;
  bit calm;
  int unsigned idle_cycles;
  int words_sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 28);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_word(out_data);
      out_ready <= !take_break();
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(sha1_in_t it);
    while (take_break()) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(it);
    words_sent++;
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [60:0] v);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_msg(int unsigned n, int unsigned vb, bit start, bit rand_vb);
    sha1_in_t it;
    for (int i = 0; i < n; i++) begin
      it.data_word = $urandom;
      it.start_msg = start && (i == 0);
      it.end_msg = (i == n - 1);
      it.valid_bytes = rand_vb ? 3'($urandom_range(7)) : (it.end_msg ? 3'(vb) : 3'd4);
      send_word(it);
    end
  endtask

  task automatic random_midstate(bit ext);
    for (int i = 0; i < 5; i++)
      write_cfg(CfgIdxW'(CFG_MID_H0 + i), ext ? (i % 2 ? 61'hFFFF_FFFF : 61'd0) : 61'($urandom));
    write_cfg(CFG_MID_LEN, ext ? {61{1'b1}} - 61'd2 : {29'($urandom), 32'($urandom)});
    write_cfg(CFG_USE_MID, 61'd1);
  endtask

  initial begin
    sha1_in_t it;
    sb = new();
    sb.init();
    in_valid = 0; in_data = '0; cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    out_ready = 0; rst_n = 0; idle_cycles = 0; words_sent = 0; calm = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty, all byte counts, block boundaries, field extremes
    for (int vb = 0; vb <= 7; vb++) send_msg(1, vb, 1, 0);
    it = '{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1}; send_word(it);
    it = '{32'h0, 3'd0, 1'b0, 1'b0}; send_word(it);
    send_msg(1, 4, 0, 0);
    send_msg(14, 4, 1, 0);
    send_msg(3, 2, 0, 0);
    drain();
    random_midstate(1);
    send_msg(2, 3, 1, 0);
    drain();
    write_cfg(CFG_USE_MID, 61'd0);

    for (int ph = 0; ph < 6 && words_sent < 450; ph++) begin
      calm = (ph == 2);
      drain();
      if (ph % 2) random_midstate(0);
      else write_cfg(CFG_USE_MID, 61'd0);
      while (words_sent < 70 * (ph + 1) + 5) begin
        case ($urandom_range(9))
          0: send_msg($urandom_range(1, 5), 0, $urandom_range(1), 1);
          1: send_msg($urandom_range(14, 18), $urandom_range(7), 1, 0);
          default: send_msg($urandom_range(1, 34), $urandom_range(4), 1, 0);
        endcase
      end
    end
    calm = 0;
    drain();
    $display("sent %0d words, checked %0d digests across iv and midstate phases",
             words_sent, sb.digests);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[sim.f]
hdl/sha1_pkg.sv
hdl/sha1_round.sv
hdl/sha1_hash_engine.sv
dv/tb_top.sv
